[design/ams_pkg.sv]
`timescale 1ns / 1ps
package ams_pkg;

  localparam logic [31:0] OP_ADD    = 32'd1;
  localparam logic [31:0] OP_SUB    = 32'd2;
  localparam logic [31:0] OP_MUL    = 32'd3;
  localparam logic [31:0] OP_DIV    = 32'd4;
  localparam logic [31:0] OP_COPY   = 32'd9;
  localparam logic [31:0] OP_LOAD   = 32'd10;
  localparam logic [31:0] OP_STORE  = 32'd11;
  localparam logic [31:0] OP_INPUT  = 32'd12;
  localparam logic [31:0] OP_OUTPUT = 32'd13;
  localparam logic [31:0] OP_STOP   = 32'd14;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_DIVZ    = 3'd2;
  localparam logic [2:0] ST_BADOP   = 3'd3;
  localparam logic [2:0] ST_BADADDR = 3'd4;

  // Memory address source selected by the controller.
  typedef enum logic [2:0] {
    RA_WRITE, RA_PC, RA_PC1, RA_PC2, RA_OPND
  } raddr_sel_e;

  // Memory write data source.
  typedef enum logic [1:0] {
    WD_IN, WD_ACC, WD_VAL, WD_DIN
  } wdata_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       rd_en;
    raddr_sel_e rd_sel;
    logic       lat_in;
    logic       lat_op;
    logic       lat_a1;
    logic       lat_a2;
    logic       lat_val;
    logic       wr_en;
    raddr_sel_e wr_sel;
    wdata_sel_e wd_sel;
    logic       acc_arith;
    logic       acc_load;
    logic       div_start;
    logic       acc_div;
    logic       pc_adv2;
    logic       pc_adv3;
    logic       out_ld;
    logic [2:0] out_status;
    logic       out_ovalid;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [31:0] opcode;
    logic        a1_bad;
    logic        a2_bad;
    logic        val_zero;
    logic        div_done;
  } sts_t;

endpackage

[design/ams_ctrl.sv]
`timescale 1ns / 1ps
module ams_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           in_operation_i,
  input  logic           wr_bad_i,
  input  logic           out_valid_i,
  input  ams_pkg::sts_t  sts_i,
  output ams_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDOP  = 4'd1;
  localparam logic [3:0] S_RDA1  = 4'd2;
  localparam logic [3:0] S_RDA2  = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_RDV   = 4'd5;
  localparam logic [3:0] S_EXEC  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_WAIT  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       op_ok;

  assign op_ok = (sts_i.opcode >= ams_pkg::OP_ADD && sts_i.opcode <= ams_pkg::OP_DIV) ||
                 (sts_i.opcode >= ams_pkg::OP_COPY && sts_i.opcode <= ams_pkg::OP_OUTPUT);

  // New items are taken only when idle and the result register is free.
  assign in_stall_o = (state_q != S_IDLE) || out_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.rd_sel = ams_pkg::RA_PC;
    cmd_o.wr_sel = ams_pkg::RA_WRITE;
    cmd_o.wd_sel = ams_pkg::WD_IN;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !out_valid_i) begin
          if (!in_operation_i) begin
            cmd_o.wr_en = !wr_bad_i;
            cmd_o.out_ld = 1'b1;
            cmd_o.out_status = wr_bad_i ? ams_pkg::ST_BADADDR : ams_pkg::ST_OK;
          end else begin
            cmd_o.lat_in = 1'b1;
            cmd_o.rd_en = 1'b1;
            cmd_o.rd_sel = ams_pkg::RA_PC;
            state_d = S_RDOP;
          end
        end
      end
      S_RDOP: begin
        cmd_o.lat_op = 1'b1;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = ams_pkg::RA_PC1;
        state_d = S_RDA1;
      end
      S_RDA1: begin
        cmd_o.lat_a1 = 1'b1;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = ams_pkg::RA_PC2;
        state_d = S_RDA2;
      end
      S_RDA2: begin
        cmd_o.lat_a2 = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        if (sts_i.opcode == ams_pkg::OP_STOP) begin
          cmd_o.out_ld = 1'b1;
          cmd_o.out_status = ams_pkg::ST_HALT;
          state_d = S_WAIT;
        end else if (!op_ok) begin
          cmd_o.out_ld = 1'b1;
          cmd_o.out_status = ams_pkg::ST_BADOP;
          state_d = S_WAIT;
        end else if (sts_i.a1_bad) begin
          cmd_o.out_ld = 1'b1;
          cmd_o.out_status = ams_pkg::ST_BADADDR;
          state_d = S_WAIT;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = ams_pkg::RA_OPND;
          state_d = S_RDV;
        end
      end
      S_RDV: begin
        cmd_o.lat_val = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_WAIT;
        cmd_o.out_ld = 1'b1;
        cmd_o.out_status = ams_pkg::ST_OK;
        cmd_o.pc_adv2 = 1'b1;
        unique case (sts_i.opcode) inside
          ams_pkg::OP_ADD, ams_pkg::OP_SUB, ams_pkg::OP_MUL: cmd_o.acc_arith = 1'b1;
          ams_pkg::OP_LOAD: cmd_o.acc_load = 1'b1;
          ams_pkg::OP_DIV: begin
            if (sts_i.val_zero) begin
              cmd_o.out_status = ams_pkg::ST_DIVZ;
              cmd_o.pc_adv2 = 1'b0;
            end else begin
              cmd_o.out_ld = 1'b0;
              cmd_o.pc_adv2 = 1'b0;
              cmd_o.div_start = 1'b1;
              state_d = S_DIV;
            end
          end
          ams_pkg::OP_COPY: begin
            cmd_o.pc_adv2 = 1'b0;
            if (sts_i.a2_bad) begin
              cmd_o.out_status = ams_pkg::ST_BADADDR;
            end else begin
              cmd_o.wr_en = 1'b1;
              cmd_o.wr_sel = ams_pkg::RA_PC2;
              cmd_o.wd_sel = ams_pkg::WD_VAL;
              cmd_o.pc_adv3 = 1'b1;
            end
          end
          ams_pkg::OP_STORE: begin
            cmd_o.wr_en = 1'b1;
            cmd_o.wr_sel = ams_pkg::RA_OPND;
            cmd_o.wd_sel = ams_pkg::WD_ACC;
          end
          ams_pkg::OP_INPUT: begin
            cmd_o.wr_en = 1'b1;
            cmd_o.wr_sel = ams_pkg::RA_OPND;
            cmd_o.wd_sel = ams_pkg::WD_DIN;
          end
          default: cmd_o.out_ovalid = 1'b1;
        endcase
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.acc_div = 1'b1;
          cmd_o.pc_adv2 = 1'b1;
          cmd_o.out_ld = 1'b1;
          cmd_o.out_status = ams_pkg::ST_OK;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        // This state lets the result register show valid before the next accept.
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/ams_dp.sv]
`timescale 1ns / 1ps
module ams_dp #(
  parameter int unsigned MEM_WORDS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ams_pkg::cmd_t        cmd_i,
  output ams_pkg::sts_t        sts_o,
  output logic                 wr_bad_o,
  input  logic [7:0]           address_i,
  input  logic signed [31:0]   data_i,
  input  logic                 out_take_i,
  output logic                 out_valid_o,
  output logic [7:0]           pc_o,
  output logic signed [31:0]   acc_o,
  output logic [2:0]           status_o,
  output logic                 ovalid_o,
  output logic signed [31:0]   ovalue_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [31:0]   mem [MEM_WORDS];
  logic [31:0]   rdata_q;
  logic [AW-1:0] pc_q, a1_q, a2_q;
  logic [31:0]   op_q, val_q, din_q;
  logic          a1_bad_q, a2_bad_q;
  logic [31:0]   acc_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;
  logic [31:0]   arith;
  logic [31:0]   prod;
  logic [7:0]    pc_rep;
  logic          out_valid_q;
  logic [7:0]    pc_out_q;
  logic [31:0]   acc_out_q, ovalue_q;
  logic [2:0]    status_q;
  logic          ovalid_q;
  // divider
  logic [31:0]   dq_q, dr_q, dd_q;
  logic [5:0]    dcnt_q;
  logic          dneg_q, dbusy_q;
  logic [32:0]   dtrial;
  logic [31:0]   dabs_a, dabs_b;

  function automatic logic [AW-1:0] sel_addr(ams_pkg::raddr_sel_e s, logic [7:0] wa,
                                              logic [AW-1:0] pc, logic [AW-1:0] a1,
                                              logic [AW-1:0] a2);
    logic [AW-1:0] r;
    r = pc;
    case (s)
      ams_pkg::RA_WRITE: r = AW'(wa);
      ams_pkg::RA_PC:    r = pc;
      ams_pkg::RA_PC1:   r = pc + AW'(1);
      ams_pkg::RA_PC2:   r = a2;
      ams_pkg::RA_OPND:  r = a1;
      default:           r = pc;
    endcase
    return r;
  endfunction

  function automatic logic bad_word(logic [31:0] w);
    return (w >= 32'(MEM_WORDS));
  endfunction

  assign wr_bad_o = (32'(address_i) >= 32'(MEM_WORDS));
  assign rd_addr = (cmd_i.rd_sel == ams_pkg::RA_PC2) ? (pc_q + AW'(2))
                 : sel_addr(cmd_i.rd_sel, address_i, pc_q, a1_q, a2_q);
  assign wr_addr = sel_addr(cmd_i.wr_sel, address_i, pc_q, a1_q, a2_q);

  always_comb begin
    case (cmd_i.wd_sel)
      ams_pkg::WD_ACC: wr_data = acc_q;
      ams_pkg::WD_VAL: wr_data = val_q;
      ams_pkg::WD_DIN: wr_data = din_q;
      default:         wr_data = data_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign prod = acc_q * val_q;
  always_comb begin
    case (op_q)
      ams_pkg::OP_ADD: arith = acc_q + val_q;
      ams_pkg::OP_SUB: arith = acc_q - val_q;
      default:         arith = prod;
    endcase
  end

  assign dabs_a = acc_q[31] ? (32'd0 - acc_q) : acc_q;
  assign dabs_b = val_q[31] ? (32'd0 - val_q) : val_q;
  assign dtrial = {dr_q, dd_q[31]} - {1'b0, dabs_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      acc_q <= '0;
      out_valid_q <= 1'b0;
      dbusy_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.acc_arith) acc_q <= arith;
      if (cmd_i.acc_load) acc_q <= val_q;
      if (cmd_i.acc_div) acc_q <= dneg_q ? (32'd0 - dq_q) : dq_q;
      if (cmd_i.pc_adv2) pc_q <= pc_q + AW'(2);
      if (cmd_i.pc_adv3) pc_q <= pc_q + AW'(3);
      if (cmd_i.div_start) begin
        dbusy_q <= 1'b1;
        dcnt_q <= 6'd32;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q - 6'd1;
        if (dcnt_q == 6'd1) dbusy_q <= 1'b0;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_take_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dd_q <= dabs_a;
      dr_q <= '0;
      dq_q <= '0;
      dneg_q <= acc_q[31] ^ val_q[31];
    end else if (dbusy_q) begin
      dd_q <= {dd_q[30:0], 1'b0};
      if (!dtrial[32]) begin
        dr_q <= dtrial[31:0];
        dq_q <= {dq_q[30:0], 1'b1};
      end else begin
        dr_q <= {dr_q[30:0], dd_q[31]};
        dq_q <= {dq_q[30:0], 1'b0};
      end
    end
    if (cmd_i.lat_in) din_q <= data_i;
    if (cmd_i.lat_op) op_q <= rdata_q;
    if (cmd_i.lat_a1) begin
      a1_q <= rdata_q[AW-1:0];
      a1_bad_q <= bad_word(rdata_q);
    end
    if (cmd_i.lat_a2) begin
      a2_q <= rdata_q[AW-1:0];
      a2_bad_q <= bad_word(rdata_q);
    end
    if (cmd_i.lat_val) val_q <= rdata_q;
  end

  always_comb begin
    pc_rep = '0;
    if (cmd_i.pc_adv2) pc_rep = 8'(pc_q + AW'(2));
    else if (cmd_i.pc_adv3) pc_rep = 8'(pc_q + AW'(3));
    else pc_rep = 8'(pc_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      pc_out_q <= pc_rep;
      status_q <= cmd_i.out_status;
      ovalid_q <= cmd_i.out_ovalid;
      ovalue_q <= cmd_i.out_ovalid ? val_q : 32'd0;
      if (cmd_i.acc_arith) acc_out_q <= arith;
      else if (cmd_i.acc_load) acc_out_q <= val_q;
      else if (cmd_i.acc_div) acc_out_q <= dneg_q ? (32'd0 - dq_q) : dq_q;
      else acc_out_q <= acc_q;
    end
  end

  assign sts_o.opcode   = op_q;
  assign sts_o.a1_bad   = a1_bad_q;
  assign sts_o.a2_bad   = a2_bad_q;
  assign sts_o.val_zero = (val_q == 32'd0);
  // The divider is finished once its last quotient bit has been shifted in.
  assign sts_o.div_done = !dbusy_q;

  assign out_valid_o = out_valid_q;
  assign pc_o     = pc_out_q;
  assign acc_o    = acc_out_q;
  assign status_o = status_q;
  assign ovalid_o = ovalid_q;
  assign ovalue_o = ovalue_q;

endmodule

[design/accumulator_machine_step_core.sv]
`timescale 1ns / 1ps
// Accumulator machine step core.
// The input channel (in_valid_i / in_stall_o) carries one item: operation,
// address and data. Operation 0 writes data into memory word address.
// Operation 1 executes the instruction at pc; the data of that item, which
// INPUT stores, is captured when the item is accepted.
// Every item yields exactly one result item on the output channel
// (out_valid_o / out_stall_i): pc, accumulator, status and the OUTPUT value.
// A memory write shows its result right after the accepting edge. An
// instruction step reads the memory in sequence (opcode, two operand words,
// data word); stop, unsupported opcodes and bad operand addresses end at
// decode, before the data word is read. A divide by a non-zero value also
// waits for the one-bit-per-cycle restoring divider.
// One item is worked on at a time; the next can be accepted in the cycle
// after the previous result has been taken.
// While the receiver stalls, the result holds in the output register and
// the input channel stalls.
// Reset clears pc, the accumulator and the controller; memory contents are
// undefined until written and need no clearing pass.
module accumulator_machine_step_core #(
  parameter int unsigned MEM_WORDS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [7:0]         address_i,
  input  logic signed [31:0] data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         program_counter_o,
  output logic signed [31:0] accumulator_o,
  output logic [2:0]         status_o,
  output logic               output_valid_o,
  output logic signed [31:0] output_value_o
);

  ams_pkg::cmd_t cmd;
  ams_pkg::sts_t sts;
  logic          wr_bad;

  ams_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_operation_i (operation_i),
    .wr_bad_i       (wr_bad),
    .out_valid_i    (out_valid_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  ams_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .wr_bad_o    (wr_bad),
    .address_i   (address_i),
    .data_i      (data_i),
    .out_take_i  (!out_stall_i),
    .out_valid_o (out_valid_o),
    .pc_o        (program_counter_o),
    .acc_o       (accumulator_o),
    .status_o    (status_o),
    .ovalid_o    (output_valid_o),
    .ovalue_o    (output_value_o)
  );

`ifndef NO_ASSERTIONS
  // No new item is taken while a result waits.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept while result pending");
  // A reported status is always one of the defined codes.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ams_pkg::ST_BADADDR))
    else $error("status code out of range");
  // Output value is only reported with an OUTPUT instruction.
  a_ovalue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !output_valid_o) |-> (output_value_o == 32'sd0))
    else $error("output value without output_valid");
`endif

endmodule

[test/ams_tb_pkg.sv]
`timescale 1ns / 1ps
package ams_tb_pkg;

  // Kind of item on the input channel.
  typedef enum logic {
    ITEM_WRITE = 1'b0,
    ITEM_STEP  = 1'b1
  } item_kind_e;

endpackage

[test/ams_checker.sv]
`timescale 1ns / 1ps
module ams_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        operation_i,
  input  logic [7:0]  address_i,
  input  logic [31:0] data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  program_counter_i,
  input  logic [31:0] accumulator_i,
  input  logic [2:0]  status_i,
  input  logic        output_valid_i,
  input  logic [31:0] output_value_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned MEM_WORDS = 256;

  typedef struct packed {
    logic [7:0]  pc;
    logic [31:0] acc;
    logic [2:0]  status;
    logic        ovalid;
    logic [31:0] ovalue;
  } step_result_t;

  logic [31:0]  shadow_mem [MEM_WORDS];
  logic [7:0]   shadow_pc;
  logic [31:0]  shadow_acc;
  step_result_t expected_q [$];

  function automatic logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic step_result_t predict_item(ams_tb_pkg::item_kind_e kind,
                                                logic [7:0] addr, logic [31:0] data);
    step_result_t r;
    logic [31:0] opc, a1, a2, v;
    logic [7:0]  step_len;
    r = '0;
    r.status = ams_pkg::ST_OK;
    if (kind == ams_tb_pkg::ITEM_WRITE) begin
      shadow_mem[addr] = data;
    end else begin
      opc = shadow_mem[shadow_pc];
      a1  = shadow_mem[shadow_pc + 8'd1];
      a2  = shadow_mem[shadow_pc + 8'd2];
      step_len = 8'd2;
      if (opc == ams_pkg::OP_STOP) begin
        r.status = ams_pkg::ST_HALT;
      end else if (!(opc >= ams_pkg::OP_ADD && opc <= ams_pkg::OP_DIV) &&
                   !(opc >= ams_pkg::OP_COPY && opc <= ams_pkg::OP_OUTPUT)) begin
        r.status = ams_pkg::ST_BADOP;
      end else if (a1 >= MEM_WORDS) begin
        r.status = ams_pkg::ST_BADADDR;
      end else begin
        v = shadow_mem[a1[7:0]];
        case (opc)
          ams_pkg::OP_ADD: shadow_acc = shadow_acc + v;
          ams_pkg::OP_SUB: shadow_acc = shadow_acc - v;
          ams_pkg::OP_MUL: shadow_acc = shadow_acc * v;
          ams_pkg::OP_DIV: begin
            if (v == 0) r.status = ams_pkg::ST_DIVZ;
            else shadow_acc = div_toward_zero(shadow_acc, v);
          end
          ams_pkg::OP_COPY: begin
            if (a2 >= MEM_WORDS) begin
              r.status = ams_pkg::ST_BADADDR;
            end else begin
              shadow_mem[a2[7:0]] = v;
              step_len = 8'd3;
            end
          end
          ams_pkg::OP_LOAD:  shadow_acc = v;
          ams_pkg::OP_STORE: shadow_mem[a1[7:0]] = shadow_acc;
          ams_pkg::OP_INPUT: shadow_mem[a1[7:0]] = data;
          default: begin
            r.ovalid = 1'b1;
            r.ovalue = v;
          end
        endcase
        if (r.status == ams_pkg::ST_OK) shadow_pc = shadow_pc + step_len;
      end
    end
    r.pc  = shadow_pc;
    r.acc = shadow_acc;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $time);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    shadow_pc    = '0;
    shadow_acc   = '0;
  end

  always @(posedge clk_i) begin
    step_result_t want;
    if (rst_ni) begin
      // The new item is queued first; the result leaving now is always older.
      if (in_valid_i && !in_stall_i)
        expected_q.insert(expected_q.size(),
                          predict_item(ams_tb_pkg::item_kind_e'(operation_i),
                                       address_i, data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", {29'd0, status_i}, '0);
        end else begin
          want = expected_q.pop_front();
          if (program_counter_i !== want.pc)
            report_mismatch("program_counter", {24'd0, program_counter_i}, {24'd0, want.pc});
          if (accumulator_i !== want.acc)
            report_mismatch("accumulator", accumulator_i, want.acc);
          if (status_i !== want.status)
            report_mismatch("status", {29'd0, status_i}, {29'd0, want.status});
          if (output_valid_i !== want.ovalid)
            report_mismatch("output_valid", {31'd0, output_valid_i}, {31'd0, want.ovalid});
          if (output_value_i !== want.ovalue)
            report_mismatch("output_value", output_value_i, want.ovalue);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;

  // Cycles without any accepted item or taken result before the run is
  // declared hung. The slowest item is a divide, the receiver also has a long
  // hold-off, and heavy random stalling adds short runs on top.
  localparam int HANG_LIMIT = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        operation_i;
  logic [7:0]  address_i;
  logic [31:0] data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  program_counter_o;
  logic [31:0] accumulator_o;
  logic [2:0]  status_o;
  logic        output_valid_o;
  logic [31:0] output_value_o;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int items_sent;
  int quiet_cycles;
  bit hold_req;
  logic [7:0] last_pc;

  accumulator_machine_step_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .address_i, .data_i,
    .out_valid_o, .out_stall_i, .program_counter_o, .accumulator_o, .status_o,
    .output_valid_o, .output_value_o
  );

  ams_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .operation_i,
    .address_i, .data_i, .out_valid_i(out_valid_o), .out_stall_i,
    .program_counter_i(program_counter_o), .accumulator_i(accumulator_o),
    .status_i(status_o), .output_valid_i(output_valid_o),
    .output_value_i(output_value_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The stimulus tracks the machine's pc from the results so that it can
  // place each new instruction exactly where the next step will fetch it.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) last_pc <= program_counter_o;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= HANG_LIMIT) begin
        $display("accumulator_machine_step_core regression: fail");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or one long hold-off when asked. The sender keeps
  // offering items during the hold-off, so the block fills and stalls its input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i) out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offers one item, with random idle cycles in front, and returns once the
  // block has taken it.
  task automatic send_item(ams_tb_pkg::item_kind_e kind, logic [7:0] addr,
                           logic [31:0] data);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= kind;
    address_i   <= addr;
    data_i      <= data;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Writes one instruction at the current pc, optionally the data word it
  // points at, and then executes it. Waits for the machine to settle first
  // so that the pc seen is the one the step will use.
  task automatic run_instr(logic [31:0] opw, logic [31:0] a1, logic [31:0] a2,
                           bit set_val, logic [31:0] val, logic [31:0] in_data);
    logic [7:0] p;
    // Withdraw the last item so that it is not taken a second time.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);
    p = last_pc;
    send_item(ams_tb_pkg::ITEM_WRITE, p, opw);
    send_item(ams_tb_pkg::ITEM_WRITE, p + 8'd1, a1);
    if (opw == ams_pkg::OP_COPY) send_item(ams_tb_pkg::ITEM_WRITE, p + 8'd2, a2);
    if (set_val && a1 < 256) send_item(ams_tb_pkg::ITEM_WRITE, a1[7:0], val);
    send_item(ams_tb_pkg::ITEM_STEP, 8'($urandom_range(255)), in_data);
  endtask

  function automatic logic [31:0] rand_operand();
    int pick;
    pick = $urandom_range(99);
    if (pick < 88) return $urandom_range(255);
    if (pick < 94) return $urandom_range(1000, 256);
    return $urandom | 32'h8000_0000;
  endfunction

  function automatic logic [31:0] rand_opcode();
    logic [31:0] good_ops [11];
    int pick;
    good_ops = '{ams_pkg::OP_ADD, ams_pkg::OP_SUB, ams_pkg::OP_MUL, ams_pkg::OP_DIV,
                 ams_pkg::OP_COPY, ams_pkg::OP_LOAD, ams_pkg::OP_STORE,
                 ams_pkg::OP_INPUT, ams_pkg::OP_OUTPUT, ams_pkg::OP_LOAD,
                 ams_pkg::OP_STOP};
    pick = $urandom_range(99);
    if (pick < 90) return good_ops[$urandom_range(10)];
    if (pick < 94) return $urandom_range(8, 5);
    if (pick < 96) return '0;
    if (pick < 98) return 32'd15;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_word();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return $urandom_range(255);
    if (pick < 6) return $urandom_range(3) - 1;
    if (pick == 6) return {pick[0], 31'h7fff_ffff} ^ 32'h8000_0000;
    return $urandom;
  endfunction

  task automatic random_items(int count, bit with_hold);
    int start;
    int pick;
    bit held;
    start = items_sent;
    held = 1'b0;
    while (items_sent - start < count) begin
      pick = $urandom_range(99);
      if (with_hold && !held && items_sent - start >= count / 2) begin
        // A burst of unsynchronized items while the receiver holds off.
        held = 1'b1;
        hold_req = 1'b1;
        repeat (20) send_item(ams_tb_pkg::ITEM_WRITE, 8'($urandom_range(255)), rand_word());
      end else if (pick < 75) begin
        run_instr(rand_opcode(), rand_operand(), rand_operand(),
                  $urandom_range(9) < 3, rand_word(), $urandom);
      end else if (pick < 90) begin
        send_item(ams_tb_pkg::ITEM_WRITE, 8'($urandom_range(255)), rand_word());
      end else begin
        send_item(ams_tb_pkg::ITEM_STEP, 8'($urandom_range(255)), $urandom);
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = ams_tb_pkg::ITEM_WRITE;
    address_i   = '0;
    data_i      = '0;
    out_stall_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    items_sent  = 0;
    quiet_cycles = 0;
    hold_req    = 1'b0;
    last_pc     = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Every word is written before any step, so no fetch ever reaches
    // memory that was never written.
    for (int i = 0; i < 256; i++) send_item(ams_tb_pkg::ITEM_WRITE, i[7:0], rand_word());

    // Directed cases: every opcode, overflow wrap, the most negative value
    // divided by minus one, divide by zero, bad operand and destination
    // addresses, unsupported opcodes and a stop that holds.
    run_instr(ams_pkg::OP_LOAD,   32'd200, '0, 1'b1, 32'h8000_0000, '0);
    run_instr(ams_pkg::OP_DIV,    32'd201, '0, 1'b1, 32'hffff_ffff, '0);
    run_instr(ams_pkg::OP_DIV,    32'd202, '0, 1'b1, 32'd0, '0);
    run_instr(ams_pkg::OP_ADD,    32'd203, '0, 1'b1, 32'h7fff_ffff, '0);
    run_instr(ams_pkg::OP_SUB,    32'd204, '0, 1'b1, 32'h8000_0000, '0);
    run_instr(ams_pkg::OP_MUL,    32'd205, '0, 1'b1, 32'hffff_fffd, '0);
    run_instr(ams_pkg::OP_DIV,    32'd206, '0, 1'b1, 32'd7, '0);
    run_instr(ams_pkg::OP_COPY,   32'd205, 32'd207, 1'b0, '0, '0);
    run_instr(ams_pkg::OP_COPY,   32'd205, 32'd300, 1'b0, '0, '0);
    run_instr(ams_pkg::OP_STORE,  32'd208, '0, 1'b0, '0, '0);
    run_instr(ams_pkg::OP_INPUT,  32'd209, '0, 1'b0, '0, 32'h8000_0000);
    run_instr(ams_pkg::OP_OUTPUT, 32'd209, '0, 1'b0, '0, '0);
    run_instr(ams_pkg::OP_INPUT,  32'd209, '0, 1'b0, '0, 32'h7fff_ffff);
    run_instr(ams_pkg::OP_OUTPUT, 32'd209, '0, 1'b0, '0, '0);
    run_instr(ams_pkg::OP_LOAD,   32'h0000_0100, '0, 1'b0, '0, '0);
    run_instr(ams_pkg::OP_LOAD,   32'hffff_ffff, '0, 1'b0, '0, '0);
    run_instr(32'd6,              32'd1, '0, 1'b0, '0, '0);
    run_instr(32'd0,              32'd1, '0, 1'b0, '0, '0);
    run_instr(32'd15,             32'd1, '0, 1'b0, '0, '0);
    run_instr(ams_pkg::OP_STOP,   32'd1, '0, 1'b0, '0, '0);
    send_item(ams_tb_pkg::ITEM_STEP, 8'hff, 32'hffff_ffff);

    // Random phases with different idling on each side.
    random_items(240, 1'b1);
    idle_pct = 84;
    random_items(240, 1'b0);
    idle_pct = 0;
    stall_pct = 84;
    random_items(240, 1'b0);
    idle_pct = 18;
    stall_pct = 18;
    random_items(240, 1'b0);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("accumulator_machine_step_core regression: pass");
    end else begin
      $display("accumulator_machine_step_core regression: fail");
    end
    $finish;
  end

endmodule
